[rtl/core/pcrc16_pkg.sv]
// Package for the CRC-16 packet append/check block: beat types, constants, CRC fold.
package pcrc16_pkg;

    localparam logic [15:0] CRC_POLY    = 16'h1021;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_MSB     = 16'h8000;
    localparam int          MAX_PAYLOAD_DEF = 252;
    localparam logic [8:0]  COUNT_MAX   = 9'd511;

    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // Output queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int PUSH_MAX    = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       end_of_packet;
        logic       crc_good;
        logic       too_long;
    } t_out_beat;

    // Fold one byte into the running CRC, MSB first, unrolled over eight bits
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if ((r & CRC_MSB) != 16'h0000) begin
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                r = {r[14:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/packet_crc16_append_check.sv]
// Top level: CRC-16-CCITT append (encode) or check-and-strip (decode) for byte packets.
// One input beat is accepted per cycle. Encode folds each byte through an unrolled
// eight-bit CRC update in the accept cycle, decode each byte as it leaves a two-byte
// delay; result beats land in a four-beat output queue the next cycle. Most bytes
// give one result beat, an encode last byte three (byte, CRC low, CRC high), a decode
// last byte up to two. Input is taken whenever the queue holds at most one beat, so
// within a packet a steady stream runs at one byte per cycle while the output is taken
// every cycle. Mode (0 appends the CRC, 1 checks and strips it) is written by the user
// through i_cfg_we / i_cfg_data only between packets; the block does not enforce it.
module packet_crc16_append_check #(
    parameter int MAX_PAYLOAD = pcrc16_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pcrc16_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcrc16_pkg::t_out_beat o_out_data
);
    import pcrc16_pkg::*;

    logic        r_mode;
    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [8:0]  r_count;
    logic [8:0]  n_count;
    logic [1:0]  r_held_cnt;
    logic [1:0]  n_held_cnt;
    logic [7:0]  r_held [2];
    logic [7:0]  n_held [2];

    logic        accept;
    logic        space;
    logic [1:0]  push_cnt;
    t_out_beat   push [PUSH_MAX];
    logic [7:0]  fold_byte;
    logic [15:0] crc_next;
    logic [8:0]  count_next;
    logic        tl;
    logic        good;

    assign o_in_ready = space;
    assign accept     = i_in_valid && space;

    // Encode folds the new byte, decode folds the oldest held byte
    assign fold_byte  = (r_mode == MODE_ENCODE) ? i_in_data.data_byte : r_held[0];
    assign crc_next   = crc_fold(r_crc, fold_byte);
    assign count_next = (r_count < COUNT_MAX) ? (r_count + 9'd1) : r_count;
    assign tl         = (count_next > 9'(MAX_PAYLOAD));

    // Work out the next state and the result beats of the current input beat
    always_comb begin
        n_crc      = r_crc;
        n_count    = r_count;
        n_held_cnt = r_held_cnt;
        n_held     = r_held;
        push_cnt   = 2'd0;
        good       = 1'b0;
        for (int k = 0; k < PUSH_MAX; k++) begin
            push[k] = '0;
        end
        if (accept) begin
            if (r_mode == MODE_ENCODE) begin
                n_crc   = crc_next;
                n_count = count_next;
                push[0] = '{out_byte: i_in_data.data_byte, byte_valid: 1'b1,
                            end_of_packet: 1'b0, crc_good: 1'b0, too_long: tl};
                push_cnt = 2'd1;
                if (i_in_data.last_byte) begin
                    push[1] = '{out_byte: crc_next[7:0], byte_valid: 1'b1,
                                end_of_packet: 1'b0, crc_good: 1'b0, too_long: tl};
                    push[2] = '{out_byte: crc_next[15:8], byte_valid: 1'b1,
                                end_of_packet: 1'b1, crc_good: 1'b0, too_long: tl};
                    push_cnt = 2'd3;
                end
            end else begin
                if (r_held_cnt >= 2'd2) begin
                    n_crc     = crc_next;
                    n_count   = count_next;
                    push[0]   = '{out_byte: r_held[0], byte_valid: 1'b1,
                                  end_of_packet: 1'b0, crc_good: 1'b0, too_long: 1'b0};
                    push_cnt  = 2'd1;
                    n_held[0] = r_held[1];
                    n_held[1] = i_in_data.data_byte;
                end else begin
                    n_held[r_held_cnt[0]] = i_in_data.data_byte;
                    n_held_cnt = r_held_cnt + 2'd1;
                end
                if (i_in_data.last_byte) begin
                    good = (n_held_cnt >= 2'd2) && ({n_held[1], n_held[0]} == n_crc);
                    push[push_cnt] = '{out_byte: 8'h00, byte_valid: 1'b0,
                                       end_of_packet: 1'b1, crc_good: good,
                                       too_long: 1'b0};
                    push_cnt = push_cnt + 2'd1;
                end
            end
            // Start afresh after the last byte
            if (i_in_data.last_byte) begin
                n_crc      = CRC_INIT;
                n_count    = 9'd0;
                n_held_cnt = 2'd0;
            end
        end
    end

    // Hold control state and the mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_ENCODE;
            r_crc      <= CRC_INIT;
            r_count    <= 9'd0;
            r_held_cnt <= 2'd0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            r_crc      <= n_crc;
            r_count    <= n_count;
            r_held_cnt <= n_held_cnt;
        end
    end

    // Hold the delayed bytes; no reset, read only once written
    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    pcrc16_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_cnt  (push_cnt),
        .i_push      (push),
        .o_space     (space),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

[rtl/core/pcrc16_outq.sv]
// Output queue: takes up to three beats per cycle, pops one per ready cycle.
module pcrc16_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push_cnt,
    input  pcrc16_pkg::t_out_beat i_push [pcrc16_pkg::PUSH_MAX],
    output logic                  o_space,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output pcrc16_pkg::t_out_beat o_out_data
);
    import pcrc16_pkg::*;

    t_out_beat  r_q [QUEUE_DEPTH];
    t_out_beat  n_q [QUEUE_DEPTH];
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic       pop;
    logic [2:0] base;
    logic [2:0] wr_idx;

    assign o_out_valid = (r_cnt != 3'd0);
    assign o_out_data  = r_q[0];
    assign pop         = o_out_valid && i_out_ready;
    // Room for a full burst once at most one beat remains
    assign o_space     = (r_cnt <= 3'd1);

    // Shift out the popped beat, then append the pushed beats behind the rest
    always_comb begin
        n_q    = r_q;
        wr_idx = 3'd0;
        if (pop) begin
            for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
                n_q[k] = r_q[k + 1];
            end
        end
        base = r_cnt - {2'b00, pop};
        for (int k = 0; k < PUSH_MAX; k++) begin
            wr_idx = base + 3'(k);
            if ((2'(k) < i_push_cnt) && (wr_idx < 3'(QUEUE_DEPTH))) begin
                n_q[wr_idx[1:0]] = i_push[k];
            end
        end
        n_cnt = base + {1'b0, i_push_cnt};
    end

    // Hold beat storage; payload needs no reset
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    // Advance the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
